/* hw/rtl/hbsc_pkg.sv */
// Shared types and constants for the FP16/BF16/FP32 format converter.
`default_nettype none

package hbsc_pkg;

    // Conversion direction held in the mode register.
    typedef enum logic [2:0] {
        MODE_F16_F32  = 3'd0,
        MODE_BF16_F32 = 3'd1,
        MODE_F32_F16  = 3'd2,
        MODE_F32_BF16 = 3'd3,
        MODE_F16_BF16 = 3'd4,
        MODE_BF16_F16 = 3'd5
    } t_mode;

    localparam int unsigned F32_W = 32;
    localparam int unsigned H16_W = 16;

    // Exponent bias difference between FP32 (127) and FP16 (15).
    localparam logic [7:0] BIAS_DIFF = 8'd112;

    // FP32 exponent range boundaries seen from the FP16 side.
    localparam logic [7:0] EXP_FLUSH_BELOW = 8'd102;
    localparam logic [7:0] EXP_SUBNORM_MAX = 8'd112;
    localparam logic [7:0] EXP_OVERFLOW    = 8'd143;
    localparam logic [7:0] SUBNORM_SHIFT_BASE = 8'd126;

    localparam logic [31:0] F32_INF_EXP   = 32'h7f80_0000;
    localparam logic [14:0] H16_INF       = 15'h7c00;
    localparam logic [23:0] H16_ROUND_ADD = 24'h00_1000;
    localparam logic [31:0] B16_ROUND_ADD = 32'h0000_7fff;

endpackage

`default_nettype wire

/* hw/rtl/hbsc_f16_widen.sv */
// Exact widening of an FP16 bit pattern to FP32, subnormals normalised.
`default_nettype none

module hbsc_f16_widen
    import hbsc_pkg::*;
(
    input  wire logic [H16_W-1:0] i_h16,
    output logic      [F32_W-1:0] o_f32
);

    logic       sign;
    logic [4:0] exp5;
    logic [9:0] man;
    logic [3:0] msb_pos;
    logic [19:0] man_shl;
    logic [9:0] man_norm;
    logic [7:0] exp_sub;

    assign sign = i_h16[15];
    assign exp5 = i_h16[14:10];
    assign man  = i_h16[9:0];

    // Position of the leading one of a subnormal mantissa.
    always_comb begin
        msb_pos = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                msb_pos = 4'(i);
            end
        end
    end

    // Shift the leading one out past bit nine; the exponent follows the shift.
    assign man_shl  = {10'd0, man} << (5'd10 - {1'b0, msb_pos});
    assign man_norm = man_shl[9:0];
    assign exp_sub  = 8'd103 + {4'd0, msb_pos};

    always_comb begin
        if (exp5 == 5'd0) begin
            if (man == 10'd0) begin
                o_f32 = {sign, 31'd0};
            end else begin
                o_f32 = {sign, exp_sub, man_norm, 13'd0};
            end
        end else if (exp5 == 5'd31) begin
            o_f32 = {sign, 31'd0} | F32_INF_EXP | {9'd0, man, 13'd0};
        end else begin
            o_f32 = {sign, ({3'd0, exp5} + BIAS_DIFF), man, 13'd0};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hbsc_f32_narrow.sv */
// Narrowing of an FP32 bit pattern to FP16 (round half up) and BF16 (nearest even).
`default_nettype none

module hbsc_f32_narrow
    import hbsc_pkg::*;
(
    input  wire logic [F32_W-1:0] i_f32,
    output logic      [H16_W-1:0] o_h16,
    output logic      [H16_W-1:0] o_b16
);

    logic        sign;
    logic [7:0]  exp8;
    logic [22:0] man;
    logic [4:0]  sub_sh;
    logic [24:0] sub_sum;
    logic [24:0] sub_res;
    logic [23:0] norm_sum;
    logic [14:0] norm_res;
    logic [4:0]  exp5;
    logic [31:0] b16_sum;

    assign sign = i_f32[31];
    assign exp8 = i_f32[30:23];
    assign man  = i_f32[22:0];

    // Subnormal FP16: shift of 14 to 24 with a half-up rounding bias.
    assign sub_sh  = 5'(SUBNORM_SHIFT_BASE - exp8);
    assign sub_sum = {2'b01, man} + (25'd1 << (sub_sh - 5'd1));
    assign sub_res = sub_sum >> sub_sh;

    // Normal FP16: a rounding carry adds into the exponent field.
    assign exp5     = 5'(exp8 - BIAS_DIFF);
    assign norm_sum = {1'b0, man} + H16_ROUND_ADD;
    assign norm_res = {exp5, 10'd0} + {4'd0, norm_sum[23:13]};

    always_comb begin
        if (exp8 < EXP_FLUSH_BELOW) begin
            o_h16 = {sign, 15'd0};
        end else if (exp8 <= EXP_SUBNORM_MAX) begin
            o_h16 = {sign, sub_res[14:0]};
        end else if (exp8 >= EXP_OVERFLOW) begin
            o_h16 = {sign, H16_INF};
        end else begin
            o_h16 = {sign, norm_res};
        end
    end

    // The add wraps at 32 bits, so an all-ones NaN comes out as zero.
    assign b16_sum = i_f32 + B16_ROUND_ADD + {31'd0, i_f32[16]};
    assign o_b16   = b16_sum[31:16];

endmodule

`default_nettype wire

/* hw/rtl/half_bfloat_single_converter_unit.sv */
// Top level of the FP16/BF16/FP32 converter: mode register, input and result registers.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------
//  input    | in        | i_in_valid / o_in_stall   | i_value_in [31:0]
//  result   | out       | o_out_valid / i_out_stall | o_value_out [31:0]
//  config   | in        | i_cfg_we                  | i_cfg_wdata [2:0]
//
// One beat is accepted per cycle while o_in_stall is low; it passes through the input register,
// one logic pass and the result register, and leaves from there while i_out_stall is low.
// A stalled result holds the result register, and the input register keeps accepting
// until it is full as well. Reset clears both valid flags and sets the mode to FP16 to FP32.
`default_nettype none

module half_bfloat_single_converter_unit
    import hbsc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [F32_W-1:0]  i_value_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [F32_W-1:0]  o_value_out
);

    t_mode              r_mode;
    logic               r_in_valid;
    logic [F32_W-1:0]   r_in_data;
    logic               r_out_valid;
    logic [F32_W-1:0]   r_out_data;

    logic               out_adv;
    logic               in_adv;
    logic [F32_W-1:0]   wide;
    logic [F32_W-1:0]   f32_src;
    logic [H16_W-1:0]   h16;
    logic [H16_W-1:0]   b16;
    logic [F32_W-1:0]   n_out_data;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;
    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_F16_F32;
        end else if (i_cfg_we) begin
            r_mode <= t_mode'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_in_data <= i_value_in;
        end
        if (out_adv && r_in_valid) begin
            r_out_data <= n_out_data;
        end
    end

    hbsc_f16_widen u_widen (
        .i_h16 (r_in_data[15:0]),
        .o_f32 (wide)
    );

    // Crossings between the 16-bit formats go through the FP32 form.
    always_comb begin
        case (r_mode)
            MODE_F16_BF16: f32_src = wide;
            MODE_BF16_F32,
            MODE_BF16_F16: f32_src = {r_in_data[15:0], 16'd0};
            default:       f32_src = r_in_data;
        endcase
    end

    hbsc_f32_narrow u_narrow (
        .i_f32 (f32_src),
        .o_h16 (h16),
        .o_b16 (b16)
    );

    always_comb begin
        case (r_mode)
            MODE_F16_F32:  n_out_data = wide;
            MODE_BF16_F32: n_out_data = f32_src;
            MODE_F32_F16,
            MODE_BF16_F16: n_out_data = {16'd0, h16};
            MODE_F32_BF16,
            MODE_F16_BF16: n_out_data = {16'd0, b16};
            default:       n_out_data = '0;
        endcase
    end

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("valid flags not cleared by reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_data))
        else $error("stalled result changed or was dropped");

    a_beat_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_adv |=> r_out_valid)
        else $error("beat in the input register did not reach the result register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled while there was room");

endmodule

`default_nettype wire

/* tb/conversion_checker.sv */
// Checker for the FP16/BF16/FP32 converter: predicts each result beat and compares it.
`default_nettype none

module conversion_checker
    import hbsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [31:0] i_value_in,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_value_out,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] source;
        logic [31:0] converted;
    } t_pending_word;

    logic [2:0]    mode_q;
    t_pending_word expected_words [$];
    int            fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mode_q       = MODE_F16_F32;
    end

    // FP16 to FP32 is exact; subnormals are normalised by shifting up to the hidden bit.
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [10:0] frac;
        logic [7:0]  expo;
        frac = {1'b0, h[9:0]};
        expo = 8'd113;
        if (h[14:10] == 5'd0) begin
            if (h[9:0] == 10'd0)
                return {h[15], 31'd0};
            while (!frac[10]) begin
                frac = frac << 1;
                expo = expo - 8'd1;
            end
            return {h[15], expo, frac[9:0], 13'd0};
        end
        if (h[14:10] == 5'h1f)
            return {h[15], 8'hff, h[9:0], 13'd0};
        expo = {3'd0, h[14:10]} + 8'd112;
        return {h[15], expo, h[9:0], 13'd0};
    endfunction

    // Round to nearest even by a wrapping add, so NaNs are not treated specially.
    function automatic logic [31:0] single_to_bfloat(input logic [31:0] f);
        logic [31:0] sum;
        sum = f + 32'h0000_7fff + {31'd0, f[16]};
        return {16'd0, sum[31:16]};
    endfunction

    function automatic logic [31:0] single_to_half(input logic [31:0] f);
        int          expo;
        int          shift;
        logic [31:0] mant;
        logic [31:0] rounded;
        expo = int'(f[30:23]);
        expo = expo - 112;
        mant = {9'd0, f[22:0]};
        if (expo < -10) begin
            rounded = 32'd0;
        end else if (expo <= 0) begin
            mant    = mant | 32'h0080_0000;
            shift   = 14 - expo;
            rounded = (mant + (32'd1 << (shift - 1))) >> shift;
        end else if (expo >= 31) begin
            rounded = 32'h0000_7c00;
        end else begin
            // A mantissa that rounds up to the next power of two carries into the exponent.
            rounded = (32'(expo) << 10) + ((mant + 32'h0000_1000) >> 13);
        end
        return {16'd0, f[31], 15'd0} | rounded;
    endfunction

    function automatic logic [31:0] convert_word(input logic [2:0] mode,
                                                 input logic [31:0] v);
        case (mode)
            MODE_F16_F32:  return half_to_single(v[15:0]);
            MODE_BF16_F32: return {v[15:0], 16'd0};
            MODE_F32_F16:  return single_to_half(v);
            MODE_F32_BF16: return single_to_bfloat(v);
            MODE_F16_BF16: return single_to_bfloat(half_to_single(v[15:0]));
            MODE_BF16_F16: return single_to_half({v[15:0], 16'd0});
            default:       return 32'd0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_pending_word head;
        if (!i_rst_n) begin
            mode_q <= MODE_F16_F32;
            expected_words.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we)
                mode_q <= i_cfg_wdata;
            // The result of a beat cannot leave on the edge that accepts it, so the
            // comparison comes before the new expectation is queued.
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: expected nothing, got 0x%08h", $time, i_value_out);
                    fails = fails + 1;
                end else begin
                    head = expected_words.pop_front();
                    if (head.converted !== i_value_out) begin
                        $display("%0t: mode %0d input 0x%08h expected 0x%08h, got 0x%08h",
                                 $time, head.mode, head.source, head.converted,
                                 i_value_out);
                        fails = fails + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back('{mode_q, i_value_in,
                                           convert_word(mode_q, i_value_in)});
            o_pending    <= expected_words.size();
            o_fail_count <= fails;
        end
    end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench top for the FP16/BF16/FP32 converter: stimulus, idling and the verdict.
`default_nettype none

module testbench
    import hbsc_pkg::*;
();

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 16;
    localparam int BEATS_PER_PHASE = 125;

    // Mode register values that select no conversion.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] word;
    } t_directed;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_wdata = 3'd0;
    logic        i_in_valid  = 1'b0;
    logic [31:0] i_value_in  = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_value_out;

    int          mismatches;
    int          outstanding;
    int          cycles   = 0;
    logic [2:0]  mode_now = MODE_F16_F32;
    bit          quiet    = 1'b0;

    // Edge cases, grouped by mode so that each group needs one register write.
    t_directed directed_beats [23] = '{
        '{MODE_F16_F32,  32'h0000_0001},   // smallest FP16 subnormal
        '{MODE_F16_F32,  32'hffff_83ff},   // negative subnormal, upper half ignored
        '{MODE_F16_F32,  32'h0000_7c00},   // infinity
        '{MODE_F16_F32,  32'h0000_fe01},   // NaN keeps its payload
        '{MODE_BF16_F32, 32'hffff_ffff},
        '{MODE_BF16_F32, 32'h0000_8000},
        '{MODE_F32_F16,  32'h32ff_ffff},   // below the flush threshold
        '{MODE_F32_F16,  32'h3300_0000},   // rounds to the smallest subnormal
        '{MODE_F32_F16,  32'h387f_f000},   // subnormal rounds up into the normal range
        '{MODE_F32_F16,  32'h477f_f000},   // carry out of the top exponent
        '{MODE_F32_F16,  32'h4780_0000},   // overflow
        '{MODE_F32_F16,  32'hffc0_0001},   // NaN becomes negative infinity
        '{MODE_F32_F16,  32'h8000_0000},
        '{MODE_F32_BF16, 32'h3f80_8000},   // tie, stays even
        '{MODE_F32_BF16, 32'h3f81_8000},   // tie, rounds up to even
        '{MODE_F32_BF16, 32'h7f7f_ffff},   // rounds to infinity
        '{MODE_F32_BF16, 32'hffff_ffff},   // wraps through the sign bit
        '{MODE_F16_BF16, 32'h0000_03ff},
        '{MODE_F16_BF16, 32'h0000_7fff},
        '{MODE_BF16_F16, 32'h0000_7fc0},
        '{MODE_BF16_F16, 32'h0000_3380},
        '{MODE_SPARE_6,  32'h1234_5678},
        '{MODE_SPARE_7,  32'h0000_0000}
    };

    half_bfloat_single_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value_in  (i_value_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value_out (o_value_out)
    );

    conversion_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_value_in   (i_value_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_value_out  (o_value_out),
        .o_fail_count (mismatches),
        .o_pending    (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The mode only changes once every beat in flight has come out.
    task automatic set_mode(input logic [2:0] mode);
        if (mode != mode_now) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (outstanding != 0);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= mode;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            mode_now = mode;
        end
    endtask

    task automatic send_beat(input logic [31:0] word);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value_in <= word;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Result side: a random hold-off before each beat, then ready until one is taken.
    initial begin
        int hold;
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 19);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [31:0] word;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_beats[i]) begin
            set_mode(directed_beats[i].mode);
            send_beat(directed_beats[i].word);
        end

        // Stepping by three visits all eight register values in turn.
        for (int phase = 0; phase < PHASES; phase++) begin
            set_mode(3'((phase * 3) % 8));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                word = $urandom();
                case ($urandom_range(0, 7))
                    0: ;
                    1: word[30:23] = 8'($urandom_range(100, 145));
                    2: word[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    3: begin
                        // Rounding boundaries on the FP16 side.
                        word[30:23] = 8'($urandom_range(100, 145));
                        if ($urandom_range(0, 1) == 1)
                            word[22:13] = 10'h3ff;
                        case ($urandom_range(0, 2))
                            0: word[12:0] = 13'h1000;
                            1: word[12:0] = 13'h0fff;
                            default: word[12:0] = 13'h1fff;
                        endcase
                    end
                    4: begin
                        word[14:10] = 5'd0;
                        word[9:0]   = word[9:0] >> $urandom_range(0, 9);
                    end
                    5: word[14:10] = $urandom_range(0, 1) ? 5'h1f : 5'h1e;
                    6: begin
                        // BF16 sources near the FP16 range, and FP32 ties for BF16.
                        word[14:7] = 8'($urandom_range(100, 145));
                        case ($urandom_range(0, 2))
                            0: word[15:0] = 16'h8000;
                            1: word[15:0] = 16'h7fff;
                            default: ;
                        endcase
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0: word = 32'h0000_0000;
                            1: word = 32'hffff_ffff;
                            2: word = 32'h8000_0000;
                            default: word = 32'h7fff_ffff;
                        endcase
                    end
                endcase
                send_beat(word);
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
